FILE: sv/bitmap_frame_allocator_assert.svh
// assertion macros for the bitmap frame allocator
// used by the top level; needs clk and rst_n in scope
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define BFA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BFA_ASSERT_NOW(lbl, pre, post, msg)
`define BFA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: sv/bfa_pkg.sv
// shared types, codes and helper functions for the bitmap frame allocator
// no dependencies
`default_nettype none
package bfa_pkg;
    localparam int DEF_MAX_FRAMES  = 32768;
    localparam int DEF_FRAME_BYTES = 4096;
    localparam int WORD_BITS       = 32;

    localparam logic [2:0] REQ_INIT    = 3'd0;
    localparam logic [2:0] REQ_RELEASE = 3'd1;
    localparam logic [2:0] REQ_RESERVE = 3'd2;
    localparam logic [2:0] REQ_READY   = 3'd3;
    localparam logic [2:0] REQ_ALLOC   = 3'd4;
    localparam logic [2:0] REQ_FREE    = 3'd5;

    typedef enum logic [2:0] {
        ST_FILL, ST_IDLE, ST_SETUP, ST_READ, ST_MOD, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SR_DONE, SR_SCAN, SR_FILL
    } setup_res_t;

    typedef enum logic {
        MR_NEXT, MR_DONE
    } mod_res_t;

    typedef enum logic [1:0] {
        OP_CLR, OP_SET, OP_FIND
    } op_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic rd;
        logic md;
        logic fill;
        logic emit;
    } cmd_t;

    typedef struct packed {
        setup_res_t setup_res;
        mod_res_t   mod_res;
        logic       fill_last;
        logic       out_free;
    } sts_t;

    function automatic logic [5:0] popcount32(input logic [WORD_BITS-1:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            n = n + 6'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [4:0] lowest_set32(input logic [WORD_BITS-1:0] v);
        logic [4:0] b;
        b = 5'd0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                b = 5'(i);
            end
        end
        return b;
    endfunction
endpackage
`default_nettype wire

FILE: sv/bitmap_frame_allocator.sv
// top level of the bitmap frame allocator: controller plus datapath
// depends on bfa_pkg, bfa_ctrl, bfa_dp and bitmap_frame_allocator_assert.svh
//
//  channel  dir  fields
//  s_*      in   tuser: req_type; tdata: address, length
//  m_*      out  tuser: status; tdata: frame_address, free_frames
//  cfg_*    in   cfg_wdata: total_frames
//
// after reset the bitmap is set to used by a fill pass over all bitmap words
// (MAX_FRAMES/32 rounded up, 1024 at default) with s_tready low; init_map runs the same pass
// before its result; region, alloc and free requests visit 32-frame bitmap words,
// with one memory read then one write per word visited
// a held result stalls the next request until m_tready takes it
`default_nettype none
module bitmap_frame_allocator #(
    parameter int MAX_FRAMES  = bfa_pkg::DEF_MAX_FRAMES,
    parameter int FRAME_BYTES = bfa_pkg::DEF_FRAME_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // address, length
    input  wire logic [2:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // frame_address, free_frames
    output logic [0:0]       m_tuser,   // status
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);
    bfa_pkg::cmd_t cmd;
    bfa_pkg::sts_t sts;

    bfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bfa_dp #(
        .MAX_FRAMES  (MAX_FRAMES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

`include "bitmap_frame_allocator_assert.svh"

    `BFA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "word taken while busy")
    `BFA_ASSERT_NOW(a_refused_zero, m_tvalid && m_tuser[0], m_tdata[31:0] == 32'd0, "refused with address")
    `BFA_ASSERT_NOW(a_free_bound, m_tvalid, 32'(m_tdata[47:32]) <= 32'(MAX_FRAMES), "free count too big")
endmodule
`default_nettype wire

FILE: sv/bfa_ctrl.sv
// controller state machine of the bitmap frame allocator
// depends on bfa_pkg; drives the datapath through cmd_t, reads sts_t
`default_nettype none
module bfa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output bfa_pkg::cmd_t      cmd,
    input  wire bfa_pkg::sts_t sts
);
    bfa_pkg::state_t state_reg, state_next;
    logic fill_req_reg, fill_req_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bfa_pkg::ST_FILL;
            fill_req_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_req_reg <= fill_req_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_req_next = fill_req_reg;
        unique case (state_reg)
            bfa_pkg::ST_FILL:
            begin
                if (sts.fill_last)
                begin
                    state_next    = fill_req_reg ? bfa_pkg::ST_DONE : bfa_pkg::ST_IDLE;
                    fill_req_next = 1'b0;
                end
            end
            bfa_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = bfa_pkg::ST_SETUP;
                end
            end
            bfa_pkg::ST_SETUP:
            begin
                unique case (sts.setup_res)
                    bfa_pkg::SR_FILL:
                    begin
                        state_next    = bfa_pkg::ST_FILL;
                        fill_req_next = 1'b1;
                    end
                    bfa_pkg::SR_SCAN: state_next = bfa_pkg::ST_READ;
                    default:          state_next = bfa_pkg::ST_DONE;
                endcase
            end
            bfa_pkg::ST_READ: state_next = bfa_pkg::ST_MOD;
            bfa_pkg::ST_MOD:
            begin
                if (sts.mod_res == bfa_pkg::MR_DONE)
                begin
                    state_next = bfa_pkg::ST_DONE;
                end
                else
                begin
                    state_next = bfa_pkg::ST_READ;
                end
            end
            bfa_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end
            default: state_next = bfa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == bfa_pkg::ST_IDLE);
        cmd.load  = (state_reg == bfa_pkg::ST_IDLE) && s_tvalid;
        cmd.setup = (state_reg == bfa_pkg::ST_SETUP);
        cmd.rd    = (state_reg == bfa_pkg::ST_READ);
        cmd.md    = (state_reg == bfa_pkg::ST_MOD);
        cmd.fill  = (state_reg == bfa_pkg::ST_FILL);
        cmd.emit  = (state_reg == bfa_pkg::ST_DONE) && sts.out_free;
    end
endmodule
`default_nettype wire

FILE: sv/bfa_dp.sv
// datapath of the bitmap frame allocator: bitmap memory, counters, result register
// depends on bfa_pkg; controlled by bfa_ctrl through cmd_t and sts_t
`default_nettype none
module bfa_dp #(
    parameter int MAX_FRAMES  = bfa_pkg::DEF_MAX_FRAMES,
    parameter int FRAME_BYTES = bfa_pkg::DEF_FRAME_BYTES
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bfa_pkg::cmd_t cmd,
    output bfa_pkg::sts_t      sts,
    input  wire logic [63:0]   s_tdata,
    input  wire logic [2:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,
    output logic [0:0]         m_tuser,
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_wdata
);
    localparam int WB    = bfa_pkg::WORD_BITS;
    localparam int WORDS = (MAX_FRAMES + WB - 1) / WB;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int XW    = WA + 5;
    localparam int NW    = XW + 1;
    localparam int SH    = $clog2(FRAME_BYTES);

    logic [WB-1:0] mem [WORDS];
    logic [WB-1:0] rdata_reg;

    logic [2:0]    type_reg;
    logic [31:0]   addr_reg, end_reg;
    logic          lenz_reg;
    logic [15:0]   total_reg;
    logic [NW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [WA-1:0] wp_reg, wp_next;
    bfa_pkg::op_t  op_reg, op_next;
    logic          phase_reg, phase_next;
    logic [NW-1:0] count_reg, count_next, ss_reg, ss_next;
    logic          ready_reg, ready_next, ok_reg, ok_next;
    logic [31:0]   fa_reg, fa_next;
    logic          ovalid_reg, ovalid_next;
    logic [31:0]   oaddr_reg;
    logic          ostat_reg;
    logic [15:0]   ofree_reg;

    logic [NW-1:0] eff_t, hm1;
    logic [32:0]   sum, s_rel, e_rel, s_res, e_res, f33;
    logic          base_odd, end_odd, misaligned;
    logic [NW-1:0] cs, ce;
    logic [WB-1:0] mask, wnew, cand;
    logic [5:0]    pc;
    logic [4:0]    fbit;
    logic [XW-1:0] ffrm;
    logic [63:0]   prod;
    logic          last_word, mem_we;
    bfa_pkg::setup_res_t sres;
    bfa_pkg::mod_res_t   mres;

    function automatic logic [NW-1:0] clamp(input logic [32:0] v, input logic [NW-1:0] t);
        return (v > 33'(t)) ? t : NW'(v);
    endfunction

    assign sum = 33'(s_tdata[31:0]) + 33'(s_tdata[63:32]);

    always_comb
    begin
        eff_t = (32'(total_reg) > 32'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : NW'(total_reg);
        base_odd   = (addr_reg & 32'(FRAME_BYTES - 1)) != 32'd0;
        end_odd    = (end_reg & 32'(FRAME_BYTES - 1)) != 32'd0;
        misaligned = base_odd;
        s_rel = 33'(addr_reg >> SH) + 33'(base_odd);
        e_rel = 33'(end_reg >> SH);
        s_res = 33'(addr_reg >> SH);
        e_res = 33'(end_reg >> SH) + 33'(end_odd);
        f33   = 33'(addr_reg >> SH);
        cs = (type_reg == bfa_pkg::REQ_RELEASE) ? clamp(s_rel, eff_t) : clamp(s_res, eff_t);
        ce = (type_reg == bfa_pkg::REQ_RELEASE) ? clamp(e_rel, eff_t) : clamp(e_res, eff_t);

        hm1  = hi_reg - NW'(1);
        last_word = (wp_reg == hm1[XW-1:5]);
        mask = '1;
        if (wp_reg == lo_reg[XW-1:5])
        begin
            mask = mask & (WB'('1) << lo_reg[4:0]);
        end
        if (last_word)
        begin
            mask = mask & (WB'('1) >> (5'd31 - hm1[4:0]));
        end
        cand = ~rdata_reg & mask;
        fbit = bfa_pkg::lowest_set32(cand);
        ffrm = {wp_reg, fbit};
        prod = 64'(ffrm) << SH;
    end

    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        wp_next    = wp_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        ss_next    = ss_reg;
        ready_next = ready_reg;
        ok_next    = ok_reg;
        fa_next    = fa_reg;
        sres       = bfa_pkg::SR_DONE;
        mres       = bfa_pkg::MR_NEXT;
        wnew       = rdata_reg;
        mem_we     = 1'b0;
        pc         = 6'd0;

        if (cmd.fill)
        begin
            wp_next = (wp_reg == WA'(WORDS - 1)) ? '0 : wp_reg + WA'(1);
        end

        if (cmd.setup)
        begin
            ok_next = 1'b1;
            fa_next = '0;
            unique case (type_reg) inside
                bfa_pkg::REQ_INIT:
                begin
                    count_next = '0;
                    ss_next    = '0;
                    ready_next = 1'b0;
                    wp_next    = '0;
                    sres       = bfa_pkg::SR_FILL;
                end
                bfa_pkg::REQ_RELEASE, bfa_pkg::REQ_RESERVE:
                begin
                    lo_next = cs;
                    hi_next = ce;
                    wp_next = cs[XW-1:5];
                    op_next = (type_reg == bfa_pkg::REQ_RELEASE) ? bfa_pkg::OP_CLR
                                                                 : bfa_pkg::OP_SET;
                    sres = (lenz_reg || cs >= ce) ? bfa_pkg::SR_DONE : bfa_pkg::SR_SCAN;
                end
                bfa_pkg::REQ_READY: ready_next = 1'b1;
                bfa_pkg::REQ_ALLOC:
                begin
                    op_next = bfa_pkg::OP_FIND;
                    if (!ready_reg || count_reg == '0)
                    begin
                        ok_next = 1'b0;
                    end
                    else if (ss_reg < eff_t)
                    begin
                        lo_next    = ss_reg;
                        hi_next    = eff_t;
                        wp_next    = ss_reg[XW-1:5];
                        phase_next = 1'b0;
                        sres       = bfa_pkg::SR_SCAN;
                    end
                    else if (eff_t != '0)
                    begin
                        lo_next    = '0;
                        hi_next    = eff_t;
                        wp_next    = '0;
                        phase_next = 1'b1;
                        sres       = bfa_pkg::SR_SCAN;
                    end
                    else
                    begin
                        ok_next = 1'b0;
                    end
                end
                bfa_pkg::REQ_FREE:
                begin
                    if (!ready_reg || misaligned || f33 >= 33'(eff_t))
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        lo_next = NW'(f33);
                        hi_next = NW'(f33) + NW'(1);
                        wp_next = f33[XW-1:5];
                        op_next = bfa_pkg::OP_CLR;
                        if (NW'(f33) < ss_reg)
                        begin
                            ss_next = NW'(f33);
                        end
                        sres = bfa_pkg::SR_SCAN;
                    end
                end
                default: ok_next = 1'b0;
            endcase
        end

        if (cmd.md)
        begin
            mem_we = 1'b1;
            case (op_reg)
                bfa_pkg::OP_CLR:
                begin
                    wnew       = rdata_reg & ~mask;
                    pc         = bfa_pkg::popcount32(rdata_reg & mask);
                    count_next = count_reg + NW'(pc);
                    mres       = last_word ? bfa_pkg::MR_DONE : bfa_pkg::MR_NEXT;
                    wp_next    = wp_reg + WA'(1);
                end
                bfa_pkg::OP_SET:
                begin
                    wnew       = rdata_reg | mask;
                    pc         = bfa_pkg::popcount32(~rdata_reg & mask);
                    count_next = (count_reg > NW'(pc)) ? count_reg - NW'(pc) : '0;
                    mres       = last_word ? bfa_pkg::MR_DONE : bfa_pkg::MR_NEXT;
                    wp_next    = wp_reg + WA'(1);
                end
                default:
                begin
                    if (cand != '0)
                    begin
                        wnew       = rdata_reg | (WB'(1) << fbit);
                        count_next = (count_reg != '0) ? count_reg - NW'(1) : '0;
                        ss_next    = NW'(ffrm) + NW'(1);
                        fa_next    = prod[31:0];
                        mres       = bfa_pkg::MR_DONE;
                    end
                    else if (!last_word)
                    begin
                        wp_next = wp_reg + WA'(1);
                    end
                    else if (!phase_reg && ss_reg != '0)
                    begin
                        lo_next    = '0;
                        hi_next    = ss_reg;
                        wp_next    = '0;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        ok_next = 1'b0;
                        mres    = bfa_pkg::MR_DONE;
                    end
                end
            endcase
        end

        ovalid_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            mem[wp_reg] <= '1;
        end
        else if (mem_we)
        begin
            mem[wp_reg] <= wnew;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[wp_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            wp_reg     <= '0;
            count_reg  <= '0;
            ss_reg     <= '0;
            ready_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            op_reg     <= bfa_pkg::OP_CLR;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
            wp_reg     <= wp_next;
            count_reg  <= count_next;
            ss_reg     <= ss_next;
            ready_reg  <= ready_next;
            ovalid_reg <= ovalid_next;
            op_reg     <= op_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= s_tuser;
            addr_reg <= s_tdata[31:0];
            end_reg  <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            lenz_reg <= (s_tdata[63:32] == 32'd0);
        end
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        ok_reg <= ok_next;
        fa_reg <= fa_next;
        if (cmd.emit)
        begin
            oaddr_reg <= fa_reg;
            ostat_reg <= ~ok_reg;
            ofree_reg <= 16'(count_reg);
        end
    end

    always_comb
    begin
        sts.setup_res = sres;
        sts.mod_res   = mres;
        sts.fill_last = cmd.fill && (wp_reg == WA'(WORDS - 1));
        sts.out_free  = !ovalid_reg || m_tready;
        m_tvalid      = ovalid_reg;
        m_tdata       = {ofree_reg, oaddr_reg};
        m_tuser       = ostat_reg;
    end
endmodule
`default_nettype wire
